FILE: rtl/core/llwd_pkg.sv
// Package for the least-loaded worker dispatcher.
// Holds operation codes, result kinds, field widths and the controller/datapath structs.
// No dependencies.
package llwd_pkg;

	localparam int OP_W   = 3;
	localparam int KEY_W  = 64;
	localparam int KIND_W = 3;
	localparam int SLOT_W = 3;
	localparam int JOB_W  = 64;

	// operation codes
	localparam logic [OP_W-1:0] OP_REGISTER   = 3'd0;
	localparam logic [OP_W-1:0] OP_UNREGISTER = 3'd1;
	localparam logic [OP_W-1:0] OP_DONE       = 3'd2;
	localparam logic [OP_W-1:0] OP_PONG       = 3'd3;
	localparam logic [OP_W-1:0] OP_TICK       = 3'd4;
	localparam logic [OP_W-1:0] OP_DISPATCH   = 3'd5;

	// result kinds
	localparam logic [KIND_W-1:0] RK_OK        = 3'd0;
	localparam logic [KIND_W-1:0] RK_TAKEN     = 3'd1;
	localparam logic [KIND_W-1:0] RK_FULL      = 3'd2;
	localparam logic [KIND_W-1:0] RK_PING      = 3'd3;
	localparam logic [KIND_W-1:0] RK_EVICTED   = 3'd4;
	localparam logic [KIND_W-1:0] RK_ASSIGNED  = 3'd5;
	localparam logic [KIND_W-1:0] RK_NO_WORKER = 3'd6;

	// controller -> datapath
	typedef struct packed {
		logic load_in;    // latch the accepted transaction, clear scan trackers
		logic scan_step;  // advance the slot scan by one
		logic tick_emit;  // emit ping/evict for the slot under scan
		logic finish;     // apply the end-of-scan action
	} llwd_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            cur_valid;
		logic            scan_end;
		logic            out_free;
	} llwd_status_t;

endpackage

FILE: rtl/core/llwd_if.sv
// Valid/ready channel interfaces for the dispatcher request and result streams.
// Depends on llwd_pkg for field widths.
interface llwd_req_if import llwd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  operation;
	logic [KEY_W-1:0] worker_key;

	modport source (output valid, output operation, output worker_key, input ready);
	modport sink (input valid, input operation, input worker_key, output ready);
endinterface

interface llwd_rsp_if import llwd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] result_kind;
	logic [SLOT_W-1:0] slot_index;
	logic [KEY_W-1:0]  key_out;
	logic [JOB_W-1:0]  job_number;
	logic              last_result;

	modport source (output valid, output result_kind, output slot_index, output key_out,
		output job_number, output last_result, input ready);
	modport sink (input valid, input result_kind, input slot_index, input key_out,
		input job_number, input last_result, output ready);
endinterface

FILE: rtl/core/llwd_ctrl.sv
// Controller FSM of the dispatcher: accept, slot scan, finish.
// Depends on llwd_pkg.
module llwd_ctrl import llwd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         req_valid,
	output logic         req_ready,
	input  llwd_status_t st,
	output llwd_cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SCAN   = 3'b010,
		S_FINISH = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   need_emit;

	always_comb begin
		need_emit = st.op inside {OP_REGISTER, OP_DISPATCH};
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_SCAN;
				end
			end
			S_SCAN: begin
				// a tick on an occupied slot waits for room in the result register
				if (st.op == OP_TICK && st.cur_valid) begin
					cmd.tick_emit = st.out_free;
					cmd.scan_step = st.out_free;
				end else begin
					cmd.scan_step = 1'b1;
				end
				if (cmd.scan_step && st.scan_end)
					state_d = S_FINISH;
			end
			S_FINISH: begin
				if (!need_emit || st.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

FILE: rtl/core/llwd_dp.sv
// Datapath of the dispatcher: slot table, scan trackers, job counter, result register.
// Depends on llwd_pkg; driven by llwd_ctrl commands.
module llwd_dp import llwd_pkg::*; #(
	parameter int SLOTS     = 8,
	parameter int LOAD_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  llwd_cmd_t         cmd,
	output llwd_status_t      st,
	input  logic [OP_W-1:0]   req_operation,
	input  logic [KEY_W-1:0]  req_worker_key,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [KIND_W-1:0] out_kind,
	output logic [SLOT_W-1:0] out_slot,
	output logic [KEY_W-1:0]  out_key,
	output logic [JOB_W-1:0]  out_job,
	output logic              out_last
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// latched transaction
	logic [OP_W-1:0]  op_q;
	logic [KEY_W-1:0] key_q;

	// slot table: valid and flag in flops, key and load in memories
	logic [SLOTS-1:0]     valid_q, valid_d;
	logic [SLOTS-1:0]     flag_q, flag_d;
	logic [KEY_W-1:0]     key_mem [SLOTS];
	logic [LOAD_BITS-1:0] load_mem [SLOTS];
	logic [KEY_W-1:0]     rd_key_q;
	logic [LOAD_BITS-1:0] rd_load_q;

	logic [IDX_W-1:0] idx_q, idx_d;
	logic             scan_end;
	logic             cur_valid;
	logic             any_above;

	// scan trackers
	logic                 free_found_q, match_found_q, best_found_q;
	logic [IDX_W-1:0]     free_idx_q, match_idx_q, best_idx_q;
	logic [LOAD_BITS-1:0] match_load_q, best_load_q;
	logic [KEY_W-1:0]     best_key_q;
	logic                 key_hit, best_hit;

	logic [JOB_W-1:0] job_q, job_d;

	// write ports and emitted result
	logic                 key_we, load_we;
	logic [IDX_W-1:0]     load_wa;
	logic [LOAD_BITS-1:0] load_wd;
	logic                 emit;
	logic [KIND_W-1:0]    e_kind;
	logic [IDX_W-1:0]     e_idx;
	logic [KEY_W-1:0]     e_key;
	logic [JOB_W-1:0]     e_job;
	logic                 e_last;
	logic                 out_valid_q;

	assign scan_end  = (idx_q == IDX_W'(SLOTS - 1));
	assign cur_valid = valid_q[idx_q];
	assign key_hit   = cur_valid && (rd_key_q == key_q);
	assign best_hit  = cur_valid && (!best_found_q || (rd_load_q < best_load_q));

	always_comb begin
		idx_d = idx_q;
		if (cmd.scan_step)
			idx_d = scan_end ? '0 : idx_q + 1'b1;
	end

	// any occupied slot above the one under scan -> not the last tick result
	always_comb begin
		any_above = 1'b0;
		for (int j = 0; j < SLOTS; j++)
			if (valid_q[j] && (IDX_W'(j) > idx_q))
				any_above = 1'b1;
	end

	always_comb begin
		st.op        = op_q;
		st.cur_valid = cur_valid;
		st.scan_end  = scan_end;
		st.out_free  = !out_valid_q || out_ready;
	end

	always_comb begin
		valid_d = valid_q;
		flag_d  = flag_q;
		job_d   = job_q;
		emit    = 1'b0;
		e_kind  = RK_OK;
		e_idx   = '0;
		e_key   = key_q;
		e_job   = '0;
		e_last  = 1'b1;
		key_we  = 1'b0;
		load_we = 1'b0;
		load_wa = match_idx_q;
		load_wd = '0;
		if (cmd.tick_emit) begin
			emit   = 1'b1;
			e_idx  = idx_q;
			e_key  = rd_key_q;
			e_last = !any_above;
			if (flag_q[idx_q]) begin
				e_kind         = RK_EVICTED;
				valid_d[idx_q] = 1'b0;
				flag_d[idx_q]  = 1'b0;
			end else begin
				e_kind        = RK_PING;
				flag_d[idx_q] = 1'b1;
			end
		end
		if (cmd.finish) begin
			case (op_q)
				OP_REGISTER: begin
					emit = 1'b1;
					if (!free_found_q) begin
						e_kind = RK_FULL;
					end else if (match_found_q) begin
						e_kind = RK_TAKEN;
						e_idx  = match_idx_q;
					end else begin
						e_kind              = RK_OK;
						e_idx               = free_idx_q;
						valid_d[free_idx_q] = 1'b1;
						flag_d[free_idx_q]  = 1'b0;
						key_we              = 1'b1;
						load_we             = 1'b1;
						load_wa             = free_idx_q;
					end
				end
				OP_UNREGISTER: begin
					if (match_found_q) begin
						valid_d[match_idx_q] = 1'b0;
						flag_d[match_idx_q]  = 1'b0;
					end
				end
				OP_DONE: begin
					if (match_found_q) begin
						flag_d[match_idx_q] = 1'b0;
						load_we             = 1'b1;
						load_wd = (match_load_q == '0) ? '0 : match_load_q - 1'b1;
					end
				end
				OP_PONG: begin
					if (match_found_q)
						flag_d[match_idx_q] = 1'b0;
				end
				OP_DISPATCH: begin
					emit = 1'b1;
					if (best_found_q) begin
						job_d   = job_q + 1'b1;
						e_kind  = RK_ASSIGNED;
						e_idx   = best_idx_q;
						e_key   = best_key_q;
						e_job   = job_q + 1'b1;
						load_we = 1'b1;
						load_wa = best_idx_q;
						load_wd = (&best_load_q) ? best_load_q : best_load_q + 1'b1;
					end else begin
						e_kind = RK_NO_WORKER;
						e_key  = '0;
					end
				end
				default: ;
			endcase
		end
	end

	// memories: one write, one registered read at the next scan index
	always_ff @(posedge clk) begin
		if (key_we)
			key_mem[free_idx_q] <= key_q;
		rd_key_q <= key_mem[idx_d];
	end

	always_ff @(posedge clk) begin
		if (load_we)
			load_mem[load_wa] <= load_wd;
		rd_load_q <= load_mem[idx_d];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q       <= '0;
			flag_q        <= '0;
			job_q         <= '0;
			idx_q         <= '0;
			free_found_q  <= 1'b0;
			match_found_q <= 1'b0;
			best_found_q  <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			valid_q <= valid_d;
			flag_q  <= flag_d;
			job_q   <= job_d;
			idx_q   <= idx_d;
			if (cmd.load_in) begin
				free_found_q  <= 1'b0;
				match_found_q <= 1'b0;
				best_found_q  <= 1'b0;
			end else if (cmd.scan_step) begin
				if (!cur_valid)
					free_found_q <= 1'b1;
				if (key_hit)
					match_found_q <= 1'b1;
				if (best_hit)
					best_found_q <= 1'b1;
			end
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q  <= req_operation;
			key_q <= req_worker_key;
		end
		if (cmd.scan_step) begin
			if (!cur_valid && !free_found_q)
				free_idx_q <= idx_q;
			if (key_hit && !match_found_q) begin
				match_idx_q  <= idx_q;
				match_load_q <= rd_load_q;
			end
			if (best_hit) begin
				best_idx_q  <= idx_q;
				best_load_q <= rd_load_q;
				best_key_q  <= rd_key_q;
			end
		end
		if (emit) begin
			out_kind <= e_kind;
			out_slot <= SLOT_W'(e_idx);
			out_key  <= e_key;
			out_job  <= e_job;
			out_last <= e_last;
		end
	end

	assign out_valid = out_valid_q;

	// a heartbeat flag only ever sits on an occupied slot
	a_flag_on_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(flag_q & ~valid_q) == '0)
		else $error("heartbeat flag on empty slot");

	// a new result is only loaded when the result register can take it
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!out_valid_q || out_ready))
		else $error("result register overwritten");

	// tick results come only from a tick scan over an occupied slot
	a_tick_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tick_emit |-> (op_q == OP_TICK && cur_valid && cmd.scan_step))
		else $error("tick result outside a tick scan");

	// the job counter moves only on a dispatch finish
	a_job_move: assert property (@(posedge clk) disable iff (!arst_n)
		(job_q != $past(job_q)) |-> $past(cmd.finish && op_q == OP_DISPATCH))
		else $error("job counter changed outside dispatch");

endmodule

FILE: rtl/core/least_loaded_worker_dispatcher.sv
// Top level of the least-loaded worker dispatcher with heartbeat.
// Depends on llwd_pkg, llwd_if, llwd_ctrl and llwd_dp.
//
// Channel  Dir  Handshake    Payload
// req      in   valid/ready  operation[2:0], worker_key[63:0]
// rsp      out  valid/ready  result_kind[2:0], slot_index[2:0], key_out[63:0],
//                            job_number[63:0], last_result
//
// One transaction at a time: after accept the block scans every slot of the
// table, then passes through the finish state before the next accept; the slot-by-slot
// scan is set by the single read port of the key and load memories.
// A tick result that finds the result register full holds the scan until rsp
// drains it; register and dispatch results wait likewise in the finish state.
// arst_n clears the valid marks, heartbeat flags, job counter and control.
// req.ready is high only while the block is idle.

module least_loaded_worker_dispatcher import llwd_pkg::*; #(
	parameter int SLOTS     = 8,
	parameter int LOAD_BITS = 16
) (
	input logic       clk,
	input logic       arst_n,
	llwd_req_if.sink   req,
	llwd_rsp_if.source rsp
);

	// command and status between the FSM and the table datapath
	llwd_cmd_t    cmd;
	llwd_status_t st;

	// The controller steps through idle -> scan -> finish. During the scan it
	// walks every slot once; the datapath keeps track of the lowest free slot,
	// the lowest matching key and the least-loaded slot as it goes, and for a
	// heartbeat tick it issues one ping or evict result per occupied slot.
	llwd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.st        (st),
		.cmd       (cmd)
	);

	// Table datapath. Key and load memories are read one slot per cycle unless a
	// tick result holds the scan; ticks update the table while scanning, and the
	// finish state does other updates and outputs a register or dispatch result.
	llwd_dp #(
		.SLOTS     (SLOTS),
		.LOAD_BITS (LOAD_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.req_operation  (req.operation),
		.req_worker_key (req.worker_key),
		.out_ready      (rsp.ready),
		.out_valid      (rsp.valid),
		.out_kind       (rsp.result_kind),
		.out_slot       (rsp.slot_index),
		.out_key        (rsp.key_out),
		.out_job        (rsp.job_number),
		.out_last       (rsp.last_result)
	);

endmodule

FILE: tb/sv/least_loaded_worker_dispatcher_tb.sv
// Self-checking testbench for the least-loaded worker dispatcher.
// Drives the request channel from a queue, predicts every result transaction and
// checks it; depends on llwd_pkg, llwd_if and the dispatcher RTL.
module least_loaded_worker_dispatcher_tb import llwd_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS     = 8;
	localparam int LOAD_BITS = 16;

	// codes the block must ignore
	localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

	// accept-to-accept latency of the block plus margin for the result register
	localparam int SETTLE         = SLOTS + 6;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_ITEMS   = 320;
	localparam int POOL_SIZE      = 12;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [KEY_W-1:0] key;
		logic             drain;  // hold off until every result is back
		logic             brisk;  // no gaps, no stalls around this one
	} request_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SLOT_W-1:0] slot;
		logic [KEY_W-1:0]  key;
		logic [JOB_W-1:0]  job;
		logic              last;
	} result_t;

	logic clk;
	logic arst_n;

	llwd_req_if req_ch ();
	llwd_rsp_if rsp_ch ();

	least_loaded_worker_dispatcher #(
		.SLOTS     (SLOTS),
		.LOAD_BITS (LOAD_BITS)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// ------------------------------------------------------------------
	// Worker table mirror: what the block should hold after each request
	// ------------------------------------------------------------------
	bit                   slot_used   [SLOTS];
	logic [KEY_W-1:0]     slot_id     [SLOTS];
	logic [LOAD_BITS-1:0] slot_jobs   [SLOTS];
	bit                   slot_pinged [SLOTS];
	logic [JOB_W-1:0]     job_seq;

	request_t    request_fifo[$];     // stimulus not yet presented
	result_t     pending_results[$];  // predicted results, oldest first
	int unsigned mismatches;
	logic [KEY_W-1:0] worker_pool[POOL_SIZE];

	// driver / monitor shared state
	bit          brisk_mode;
	int unsigned gap_left;
	int unsigned hold_left;
	int unsigned stall_left;
	int unsigned idle_cycles;

	function automatic int find_worker(input logic [KEY_W-1:0] key);
		int hit;
		hit = -1;
		for (int i = SLOTS - 1; i >= 0; i--)
			if (slot_used[i] && slot_id[i] == key)
				hit = i;
		return hit;
	endfunction

	function automatic void release_slot(input int i);
		slot_used[i]   = 1'b0;
		slot_id[i]     = '0;
		slot_jobs[i]   = '0;
		slot_pinged[i] = 1'b0;
	endfunction

	// Update the mirror for one accepted request and queue the results it causes.
	function automatic void apply_request(input logic [OP_W-1:0] op,
		input logic [KEY_W-1:0] key);
		int      hit;
		int      free_idx;
		int      best;
		int      n;
		result_t batch[SLOTS];
		hit      = find_worker(key);
		free_idx = -1;
		best     = -1;
		n        = 0;
		for (int i = SLOTS - 1; i >= 0; i--)
			if (!slot_used[i])
				free_idx = i;
		case (op)
			OP_REGISTER: begin
				// full wins over name taken
				if (free_idx < 0) begin
					batch[0] = '{RK_FULL, '0, key, '0, 1'b0};
				end else if (hit >= 0) begin
					batch[0] = '{RK_TAKEN, SLOT_W'(hit), key, '0, 1'b0};
				end else begin
					slot_used[free_idx]   = 1'b1;
					slot_id[free_idx]     = key;
					slot_jobs[free_idx]   = '0;
					slot_pinged[free_idx] = 1'b0;
					batch[0] = '{RK_OK, SLOT_W'(free_idx), key, '0, 1'b0};
				end
				n = 1;
			end
			OP_UNREGISTER: begin
				if (hit >= 0)
					release_slot(hit);
			end
			OP_DONE: begin
				if (hit >= 0) begin
					slot_pinged[hit] = 1'b0;
					if (slot_jobs[hit] != '0)
						slot_jobs[hit] = slot_jobs[hit] - 1'b1;
				end
			end
			OP_PONG: begin
				if (hit >= 0)
					slot_pinged[hit] = 1'b0;
			end
			OP_TICK: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (slot_used[i]) begin
						if (slot_pinged[i]) begin
							batch[n] = '{RK_EVICTED, SLOT_W'(i), slot_id[i], '0, 1'b0};
							release_slot(i);
						end else begin
							slot_pinged[i] = 1'b1;
							batch[n] = '{RK_PING, SLOT_W'(i), slot_id[i], '0, 1'b0};
						end
						n = n + 1;
					end
				end
			end
			OP_DISPATCH: begin
				for (int i = 0; i < SLOTS; i++)
					if (slot_used[i] && (best < 0 || slot_jobs[i] < slot_jobs[best]))
						best = i;
				if (best < 0) begin
					batch[0] = '{RK_NO_WORKER, '0, '0, '0, 1'b0};
				end else begin
					job_seq = job_seq + 1'b1;
					if (slot_jobs[best] != '1)
						slot_jobs[best] = slot_jobs[best] + 1'b1;
					batch[0] = '{RK_ASSIGNED, SLOT_W'(best), slot_id[best], job_seq, 1'b0};
				end
				n = 1;
			end
			default: ;
		endcase
		if (n > 0)
			batch[n-1].last = 1'b1;
		for (int k = 0; k < n; k++)
			pending_results.push_back(batch[k]);
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// mostly back-to-back, some short pauses, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void push_item(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
		input bit drain = 1'b0, input bit brisk = 1'b0);
		request_fifo.push_back('{op, key, drain, brisk});
	endfunction

	// Random request aimed at the key pool so most hit live workers;
	// returns 0 for the codes the block ignores.
	function automatic bit push_random_item(input bit drain, input bit brisk);
		int unsigned      r;
		logic [OP_W-1:0]  op;
		logic [KEY_W-1:0] key;
		r = $urandom_range(0, 99);
		if (r < 24)
			op = OP_REGISTER;
		else if (r < 32)
			op = OP_UNREGISTER;
		else if (r < 47)
			op = OP_DONE;
		else if (r < 62)
			op = OP_PONG;
		else if (r < 72)
			op = OP_TICK;
		else if (r < 97)
			op = OP_DISPATCH;
		else
			op = ($urandom_range(0, 1) != 0) ? OP_SPARE_B : OP_SPARE_A;
		if ($urandom_range(0, 99) < 85)
			key = worker_pool[$urandom_range(0, POOL_SIZE - 1)];
		else
			key = {$urandom(), $urandom()};
		push_item(op, key, drain, brisk);
		return op <= OP_DISPATCH;
	endfunction

	// ------------------------------------------------------------------
	// Clock
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Request driver. On an accepted transaction the mirror is advanced first,
	// so a drain request sees the results of the one just taken.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : drive_requests
		request_t nxt;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			gap_left     <= 0;
			hold_left    <= SETTLE;
			brisk_mode   <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				apply_request(req_ch.operation, req_ch.worker_key);

			if (req_ch.valid && !req_ch.ready) begin
				// waiting for the block; payload stays put
			end else if (gap_left != 0) begin
				req_ch.valid <= 1'b0;
				gap_left     <= gap_left - 1;
			end else if (request_fifo.size() == 0) begin
				req_ch.valid <= 1'b0;
			end else if (request_fifo[0].drain &&
				(pending_results.size() != 0 || hold_left != 0)) begin
				// pressure point: let the result side empty out, then settle
				req_ch.valid <= 1'b0;
				if (pending_results.size() != 0)
					hold_left <= SETTLE;
				else
					hold_left <= hold_left - 1;
			end else begin
				nxt = request_fifo.pop_front();
				req_ch.valid      <= 1'b1;
				req_ch.operation  <= nxt.op;
				req_ch.worker_key <= nxt.key;
				brisk_mode        <= nxt.brisk;
				gap_left          <= nxt.brisk ? 0 : pick_gap();
				hold_left         <= SETTLE;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor: compares each result transaction with the oldest
	// prediction and applies random back-pressure.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		result_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left   <= 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t ns: extra result, expected none, actual %0d %0d %0h %0h %0b",
						$time, rsp_ch.result_kind, rsp_ch.slot_index, rsp_ch.key_out,
						rsp_ch.job_number, rsp_ch.last_result);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					check_field("result_kind", 64'(want.kind), 64'(rsp_ch.result_kind));
					check_field("slot_index", 64'(want.slot), 64'(rsp_ch.slot_index));
					check_field("key_out", want.key, rsp_ch.key_out);
					check_field("job_number", want.job, rsp_ch.job_number);
					check_field("last_result", 64'(want.last), 64'(rsp_ch.last_result));
				end
			end

			if (stall_left != 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left   <= stall_left - 1;
			end else if (!brisk_mode && $urandom_range(0, 3) == 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left   <= pick_gap();
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: counts cycles in which neither channel moves a transaction
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("%0t ns: watchdog, no transaction for %0d cycles, %0d results outstanding",
			$time, WATCHDOG_LIMIT, pending_results.size());
		$display("CHECKS FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------
	initial begin
		int unsigned counted;
		int unsigned idx;
		bit          real_op;

		// known values on every input from time zero
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.operation  = OP_REGISTER;
		req_ch.worker_key = '0;
		rsp_ch.ready      = 1'b0;
		idle_cycles       = 0;
		mismatches        = 0;
		job_seq           = '0;
		for (int i = 0; i < SLOTS; i++)
			release_slot(i);

		// pool holds both key extremes and more names than the table has slots
		worker_pool[0] = '0;
		worker_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			worker_pool[i] = {$urandom(), $urandom()};

		// --- directed part ---
		push_item(OP_DISPATCH, worker_pool[3]);       // empty table: no worker
		push_item(OP_TICK, worker_pool[3]);           // empty table: no result at all
		push_item(OP_REGISTER, worker_pool[0]);       // all-zero key -> slot 0
		push_item(OP_REGISTER, worker_pool[1]);       // all-ones key -> slot 1
		push_item(OP_REGISTER, worker_pool[0]);       // name taken
		push_item(OP_UNREGISTER, worker_pool[11]);    // unknown key ignored
		push_item(OP_DONE, worker_pool[11]);
		push_item(OP_PONG, worker_pool[11]);
		push_item(OP_SPARE_A, worker_pool[1]);        // spare codes ignored
		push_item(OP_SPARE_B, worker_pool[0]);
		push_item(OP_DONE, worker_pool[0]);           // load already zero stays zero
		push_item(OP_DISPATCH, worker_pool[3]);       // slot 0
		push_item(OP_DISPATCH, worker_pool[3]);       // slot 1
		push_item(OP_DISPATCH, worker_pool[3]);       // tie -> lowest index
		push_item(OP_TICK, worker_pool[3]);           // ping both
		push_item(OP_PONG, worker_pool[1]);
		push_item(OP_TICK, worker_pool[3]);           // evict slot 0, ping slot 1
		for (int i = 2; i <= 8; i++)
			push_item(OP_REGISTER, worker_pool[i]);   // fill the table
		push_item(OP_REGISTER, worker_pool[9]);       // table full
		push_item(OP_REGISTER, worker_pool[1]);       // full beats name taken
		push_item(OP_TICK, worker_pool[3], 1'b1);     // one result per slot
		push_item(OP_UNREGISTER, worker_pool[2]);
		push_item(OP_TICK, worker_pool[3]);           // evicts everyone left

		// a lone worker takes a run of jobs back to back
		push_item(OP_REGISTER, worker_pool[10], 1'b1, 1'b1);
		for (int i = 0; i < 8; i++)
			push_item(OP_DISPATCH, worker_pool[10], 1'b0, 1'b1);
		push_item(OP_DONE, worker_pool[10], 1'b0, 1'b1);
		push_item(OP_DISPATCH, worker_pool[10], 1'b0, 1'b1);

		// --- random part ---
		counted = 0;
		idx     = 0;
		while (counted < RANDOM_ITEMS) begin
			real_op = push_random_item(idx % 75 == 0, idx >= 150 && idx < 200);
			if (real_op)
				counted++;
			idx++;
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (request_fifo.size() != 0 || req_ch.valid)
			@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		// catch anything the block sends beyond the predictions
		repeat (4 * (SLOTS + 2)) @(posedge clk);

		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
